FILE: rtl/frpg_pkg.sv
// Package for the fixed radius point graph: field widths, constants,
// the queued point item, the result beat and the engine state type.
// Used by every other file of the block.
package frpg_pkg;

   localparam int COORD_W = 16;
   localparam int POINT_W = 3 * COORD_W;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;
   localparam int EDGE_W  = 11;
   localparam int LINK_W  = 15;
   localparam int LIM_W   = 2 * LINK_W;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int SUM_W   = SQ_W + 2;

   localparam logic [LINK_W-1:0] LINK_RESET = 15'd1536;
   localparam logic [EDGE_W-1:0] EDGE_SAT   = 11'd2047;

   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
      logic                      first_point;
      logic                      last_point;
   } item_type;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] older_index;
      logic [INDEX_W-1:0] newer_index;
      logic [COUNT_W-1:0] node_total;
      logic [EDGE_W-1:0]  edge_total;
      logic               overflow;
      logic               run_end;
   } rsp_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_FLUSH,
      ENG_SUMMARY
   } eng_state_type;

endpackage

FILE: rtl/frpg_if.sv
// Channel interfaces of the point graph block: the point input channel
// and the result channel, each with valid, ready and the payload fields.
// Depends on frpg_pkg.
interface frpg_req_if import frpg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] px;
   logic signed [COORD_W-1:0] py;
   logic signed [COORD_W-1:0] pz;
   logic                      first_point;
   logic                      last_point;

   modport source (output valid, px, py, pz, first_point, last_point, input ready);
   modport sink (input valid, px, py, pz, first_point, last_point, output ready);
endinterface

interface frpg_rsp_if import frpg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [INDEX_W-1:0] older_index;
   logic [INDEX_W-1:0] newer_index;
   logic [COUNT_W-1:0] node_total;
   logic [EDGE_W-1:0]  edge_total;
   logic               overflow;
   logic               run_end;

   modport source (output valid, kind, older_index, newer_index, node_total, edge_total,
                   overflow, run_end, input ready);
   modport sink (input valid, kind, older_index, newer_index, node_total, edge_total,
                 overflow, run_end, output ready);
endinterface

FILE: rtl/frpg_front.sv
// Front end of the point graph block: accepts point beats and holds them
// in a two-entry queue until the engine takes them.
// Depends on frpg_pkg and frpg_req_if.
module frpg_front import frpg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   frpg_req_if.sink         req,
   output logic             q_valid,
   output item_type         q_item,
   input  logic             q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       push;
   logic       pop;
   item_type   in_item;

   assign req.ready = (fill_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign pop       = q_pop && (fill_ff != 2'd0);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   assign in_item.px          = req.px;
   assign in_item.py          = req.py;
   assign in_item.pz          = req.pz;
   assign in_item.first_point = req.first_point;
   assign in_item.last_point  = req.last_point;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

FILE: rtl/frpg_engine.sv
// Back end of the point graph block: point store, distance pipeline over
// the stored points, edge and summary sequencing and the result register.
// Depends on frpg_pkg and frpg_rsp_if.
module frpg_engine import frpg_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  item_type         q_item,
   output logic             q_pop,
   input  logic [LIM_W-1:0] link_limit,
   frpg_rsp_if.source       rsp
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_POINTS);

   logic [POINT_W-1:0] store_mem [MAX_POINTS];

   eng_state_type state_ff;
   eng_state_type state_in;
   item_type      item_ff;

   logic [COUNT_W-1:0] count_ff;
   logic [EDGE_W-1:0]  edges_ff;
   logic               dropped_ff;
   logic [COUNT_W-1:0] j_ff;

   logic               s1_valid_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic [POINT_W-1:0] rd_ff;
   logic               s2_valid_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic signed [DIFF_W-1:0] dx_ff;
   logic signed [DIFF_W-1:0] dy_ff;
   logic signed [DIFF_W-1:0] dz_ff;
   logic               s3_valid_ff;
   logic [IDX_W-1:0]   s3_idx_ff;
   logic [SQ_W-1:0]    sqx_ff;
   logic [SQ_W-1:0]    sqy_ff;
   logic [SQ_W-1:0]    sqz_ff;

   logic               pend_valid_ff;
   logic [IDX_W-1:0]   pend_idx_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               pipe_en;
   logic [COUNT_W-1:0] eff_count;
   logic               store_full;
   logic               scan_done;
   logic               issue;
   logic               flush_go;
   logic               hit;
   logic               o_load;
   rsp_type            o_data;
   rsp_type            edge_data;
   rsp_type            summary_data;
   logic [SUM_W-1:0]   dist_sum;
   logic [DIFF_W-1:0]  ax;
   logic [DIFF_W-1:0]  ay;
   logic [DIFF_W-1:0]  az;

   assign pipe_en    = !rsp_valid_ff || rsp.ready;
   assign eff_count  = q_item.first_point ? '0 : count_ff;
   assign store_full = (eff_count >= MAX_COUNT);
   assign scan_done  = (j_ff == count_ff) && !s1_valid_ff && !s2_valid_ff && !s3_valid_ff;
   assign dist_sum   = SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);
   assign hit        = s3_valid_ff && (dist_sum <= SUM_W'(link_limit));

   assign ax = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
   assign ay = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);
   assign az = dz_ff[DIFF_W-1] ? DIFF_W'(-dz_ff) : DIFF_W'(dz_ff);

   always_comb begin
      edge_data             = '0;
      edge_data.kind        = KIND_EDGE;
      edge_data.older_index = INDEX_W'(pend_idx_ff);
      edge_data.newer_index = INDEX_W'(count_ff[IDX_W-1:0]);
      summary_data            = '0;
      summary_data.kind       = KIND_SUMMARY;
      summary_data.node_total = count_ff;
      summary_data.edge_total = edges_ff;
      summary_data.overflow   = dropped_ff;
      summary_data.run_end    = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: begin
            if (q_valid) begin
               if (!store_full) begin
                  state_in = ENG_SCAN;
               end else if (q_item.last_point) begin
                  state_in = ENG_SUMMARY;
               end
            end
         end
         ENG_SCAN: begin
            if (scan_done) begin
               state_in = ENG_FLUSH;
            end
         end
         ENG_FLUSH: begin
            if (flush_go) begin
               state_in = item_ff.last_point ? ENG_SUMMARY : ENG_IDLE;
            end
         end
         ENG_SUMMARY: begin
            if (pipe_en) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      issue    = 1'b0;
      flush_go = 1'b0;
      o_load   = 1'b0;
      o_data   = edge_data;
      unique case (state_ff)
         ENG_IDLE: begin
            q_pop = q_valid;
         end
         ENG_SCAN: begin
            issue  = pipe_en && (j_ff < count_ff);
            o_load = hit && pend_valid_ff;
         end
         ENG_FLUSH: begin
            flush_go       = !pend_valid_ff || pipe_en;
            o_load         = pend_valid_ff;
            o_data.run_end = !item_ff.last_point;
         end
         ENG_SUMMARY: begin
            o_load = 1'b1;
            o_data = summary_data;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ENG_IDLE;
         count_ff      <= '0;
         edges_ff      <= '0;
         dropped_ff    <= 1'b0;
         j_ff          <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop) begin
            j_ff <= '0;
            if (q_item.first_point) begin
               count_ff   <= '0;
               edges_ff   <= '0;
               dropped_ff <= 1'b0;
            end
            if (store_full) begin
               dropped_ff <= 1'b1;
            end
         end
         if (pipe_en) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            rsp_valid_ff <= o_load;
            if (issue) begin
               j_ff <= j_ff + 1'b1;
            end
            if (hit) begin
               pend_valid_ff <= 1'b1;
               if (edges_ff < EDGE_SAT) begin
                  edges_ff <= edges_ff + 1'b1;
               end
            end
         end
         if (flush_go) begin
            pend_valid_ff <= 1'b0;
            count_ff      <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (pipe_en) begin
         s1_idx_ff <= j_ff[IDX_W-1:0];
         s2_idx_ff <= s1_idx_ff;
         s3_idx_ff <= s2_idx_ff;
         dx_ff <= DIFF_W'(item_ff.px) - DIFF_W'($signed(rd_ff[POINT_W-1 -: COORD_W]));
         dy_ff <= DIFF_W'(item_ff.py) - DIFF_W'($signed(rd_ff[2*COORD_W-1 -: COORD_W]));
         dz_ff <= DIFF_W'(item_ff.pz) - DIFF_W'($signed(rd_ff[COORD_W-1:0]));
         sqx_ff <= SQ_W'(ax[COORD_W-1:0]) * SQ_W'(ax[COORD_W-1:0]);
         sqy_ff <= SQ_W'(ay[COORD_W-1:0]) * SQ_W'(ay[COORD_W-1:0]);
         sqz_ff <= SQ_W'(az[COORD_W-1:0]) * SQ_W'(az[COORD_W-1:0]);
         if (hit) begin
            pend_idx_ff <= s3_idx_ff;
         end
         if (o_load) begin
            rsp_ff <= o_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ff <= store_mem[j_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (flush_go) begin
         store_mem[count_ff[IDX_W-1:0]] <= {item_ff.px, item_ff.py, item_ff.pz};
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = rsp_ff.kind;
   assign rsp.older_index = rsp_ff.older_index;
   assign rsp.newer_index = rsp_ff.newer_index;
   assign rsp.node_total  = rsp_ff.node_total;
   assign rsp.edge_total  = rsp_ff.edge_total;
   assign rsp.overflow    = rsp_ff.overflow;
   assign rsp.run_end     = rsp_ff.run_end;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("Stored point count exceeds the store depth.");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_SCAN |-> j_ff <= count_ff)
      else $error("Scan index ran past the stored points.");

   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ENG_SCAN |-> !s1_valid_ff && !s2_valid_ff && !s3_valid_ff)
      else $error("Distance pipeline busy outside a scan.");

   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_IDLE || state_ff == ENG_SUMMARY |-> !pend_valid_ff)
      else $error("Held edge left behind at the end of an item.");

   a_summary_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_SUMMARY |-> rsp_ff.run_end)
      else $error("Summary beat does not close its item.");
`endif

endmodule

FILE: rtl/fixed_radius_point_graph.sv
// Fixed radius point graph over a stream of 3-D points in signed Q8.8.
// Each point kept is checked against all stored points; every pair within the
// link distance gives an edge beat, and a point flagged last adds a summary
// beat with the node count, the saturating edge count and the overflow flag.
// Channels: req carries one point per beat, rsp one result per beat, with
// run_end set on the last beat that a point causes. csr_wr_en writes the
// 15-bit link distance (unsigned Q7.8) from csr_wr_data; reset value is 6.0.
// Flow: the engine takes a point from the head of the queue only when it is
// done with the last one, and reads one stored point per cycle, while the
// result register is not stalled, through the single read port of the
// point store and a three-stage distance pipeline. Up to two points queue
// in front while the engine works.
// Reset clears counts, flags, the queue and the result valid flag; the link
// distance returns to 6.0. Store entries are written before they are read.
// When the receiver stalls, the result register holds its beat and the
// distance pipeline freezes; the input queue keeps taking beats until full.
module fixed_radius_point_graph import frpg_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   frpg_req_if.sink          req,
   frpg_rsp_if.source        rsp,
   input  logic              csr_wr_en,
   input  logic [LINK_W-1:0] csr_wr_data
);

   logic [LINK_W-1:0] link_ff;
   logic [LIM_W-1:0]  limit_ff;
   logic              q_valid;
   item_type          q_item;
   logic              q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= LINK_RESET;
      end else if (csr_wr_en) begin
         link_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= LIM_W'(link_ff) * LIM_W'(link_ff);
   end

   frpg_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   frpg_engine #(
      .MAX_POINTS (MAX_POINTS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .link_limit (limit_ff),
      .rsp        (rsp)
   );

endmodule
